FILE: hw/rtl/sgs_pkg.sv
// Shared types, constants and helpers for the sandpile grid step core.
`timescale 1ns / 1ps
package sgs_pkg;

   localparam int GRID_WIDTH_DEFAULT  = 15;
   localparam int GRID_HEIGHT_DEFAULT = 15;

   localparam int COLOR_WIDTH     = 24;
   localparam int LEVEL_WIDTH     = 8;
   localparam int COUNT_WIDTH     = 8;
   localparam int COORD_WIDTH     = 4;
   localparam int COORD_EXT_WIDTH = 6;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [LEVEL_WIDTH-1:0] TOPPLE_LIMIT = 8'd3;
   localparam logic [LEVEL_WIDTH-1:0] GRAIN_LOSS   = 8'd4;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX    = 8'hFF;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = 8'hFF;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] REG_LEVEL1_COLOR   = 2'd0;
   localparam logic [1:0] REG_LEVEL2_COLOR   = 2'd1;
   localparam logic [1:0] REG_LEVEL3_COLOR   = 2'd2;
   localparam logic [1:0] REG_OVERFLOW_COLOR = 2'd3;

   typedef struct packed {
      logic                   cmd;
      logic [COORD_WIDTH-1:0] col;
      logic [COORD_WIDTH-1:0] row;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_WIDTH-1:0] pixel_color;
      logic [LEVEL_WIDTH-1:0] cell_level;
      logic [COUNT_WIDTH-1:0] toppled_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [COLOR_WIDTH-1:0] level1;
      logic [COLOR_WIDTH-1:0] level2;
      logic [COLOR_WIDTH-1:0] level3;
      logic [COLOR_WIDTH-1:0] overflow;
   } color_set_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAIN,
      ST_TOPPLE,
      ST_COUNT,
      ST_FETCH,
      ST_SEND_TICK,
      ST_SEND_READ
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic add_grain;
      logic topple;
      logic scan_step;
      logic fetch;
      logic load_tick;
      logic load_read;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_hold;
   } dp_status_type;

   function automatic logic [COLOR_WIDTH-1:0] color_of(
      input logic [LEVEL_WIDTH-1:0] level,
      input color_set_type          colors
   );
      logic [COLOR_WIDTH-1:0] result;
      unique case (level)
         8'd0:    result = '0;
         8'd1:    result = colors.level1;
         8'd2:    result = colors.level2;
         8'd3:    result = colors.level3;
         default: result = colors.overflow;
      endcase
      return result;
   endfunction

endpackage

FILE: hw/rtl/sgs_ctrl.sv
// Sequencing state machine for ticks and cell reads.
`timescale 1ns / 1ps
module sgs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   output sgs_pkg::dp_cmd_type    dp_cmd,
   input  sgs_pkg::dp_status_type dp_status
);

   sgs_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == sgs_pkg::CMD_TICK) ? sgs_pkg::ST_GRAIN
                                                         : sgs_pkg::ST_FETCH;
            end
         end
         sgs_pkg::ST_GRAIN:  state_in = sgs_pkg::ST_TOPPLE;
         sgs_pkg::ST_TOPPLE: state_in = sgs_pkg::ST_COUNT;
         sgs_pkg::ST_COUNT: begin
            if (dp_status.scan_last) begin
               state_in = sgs_pkg::ST_SEND_TICK;
            end
         end
         sgs_pkg::ST_FETCH:  state_in = sgs_pkg::ST_SEND_READ;
         sgs_pkg::ST_SEND_TICK, sgs_pkg::ST_SEND_READ: begin
            if (!dp_status.rsp_hold) begin
               state_in = sgs_pkg::ST_IDLE;
            end
         end
         default: state_in = sgs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         sgs_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            dp_cmd.capture = req_valid;
         end
         sgs_pkg::ST_GRAIN:     dp_cmd.add_grain = 1'b1;
         sgs_pkg::ST_TOPPLE:    dp_cmd.topple    = 1'b1;
         sgs_pkg::ST_COUNT:     dp_cmd.scan_step = 1'b1;
         sgs_pkg::ST_FETCH:     dp_cmd.fetch     = 1'b1;
         sgs_pkg::ST_SEND_TICK: dp_cmd.load_tick = !dp_status.rsp_hold;
         sgs_pkg::ST_SEND_READ: dp_cmd.load_read = !dp_status.rsp_hold;
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/sgs_datapath.sv
// Sand grid cell array, toppled-cell counter, read path and result register.
`timescale 1ns / 1ps
module sgs_datapath #(
   parameter int GRID_WIDTH  = sgs_pkg::GRID_WIDTH_DEFAULT,
   parameter int GRID_HEIGHT = sgs_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sgs_pkg::dp_cmd_type      dp_cmd,
   output sgs_pkg::dp_status_type   dp_status,
   input  sgs_pkg::req_payload_type req_payload,
   input  sgs_pkg::color_set_type   colors,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sgs_pkg::rsp_payload_type rsp_payload
);

   localparam int CW         = $clog2(GRID_WIDTH);
   localparam int RW         = $clog2(GRID_HEIGHT);
   localparam int CENTER_COL = GRID_WIDTH / 2;
   localparam int CENTER_ROW = GRID_HEIGHT / 2;
   localparam int LW         = sgs_pkg::LEVEL_WIDTH;
   localparam int XW         = sgs_pkg::COORD_EXT_WIDTH;

   logic [LW-1:0] level_ff   [GRID_HEIGHT][GRID_WIDTH];
   logic [LW-1:0] level_in   [GRID_HEIGHT][GRID_WIDTH];
   logic [LW-1:0] toppled_lv [GRID_HEIGHT][GRID_WIDTH];
   logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] hot;
   logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] flag_ff, flag_in;

   logic [CW-1:0] scan_col_ff, scan_col_in;
   logic [RW-1:0] scan_row_ff, scan_row_in;
   logic [sgs_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic [XW-1:0] rd_col_ff, rd_col_in;
   logic [XW-1:0] rd_row_ff, rd_row_in;
   logic [LW-1:0] rd_level_ff, rd_level_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   sgs_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic scan_last;
   logic rd_inside;

   // One toppling pass: every cell judged on the current levels.
   for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_row
      for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
         logic w_b, e_b, n_b, s_b;
         logic [2:0]  gain;
         logic [LW:0] sum;

         assign hot[r][c] = level_ff[r][c] > sgs_pkg::TOPPLE_LIMIT;
         if (c > 0) begin : g_w
            assign w_b = hot[r][c-1];
         end else begin : g_nw
            assign w_b = 1'b0;
         end
         if (c < GRID_WIDTH - 1) begin : g_e
            assign e_b = hot[r][c+1];
         end else begin : g_ne
            assign e_b = 1'b0;
         end
         if (r > 0) begin : g_n
            assign n_b = hot[r-1][c];
         end else begin : g_nn
            assign n_b = 1'b0;
         end
         if (r < GRID_HEIGHT - 1) begin : g_s
            assign s_b = hot[r+1][c];
         end else begin : g_ns
            assign s_b = 1'b0;
         end

         assign gain = 3'({2'b00, w_b}) + 3'({2'b00, e_b})
                     + 3'({2'b00, n_b}) + 3'({2'b00, s_b});
         assign sum  = {1'b0, level_ff[r][c]}
                     - (hot[r][c] ? {1'b0, sgs_pkg::GRAIN_LOSS} : '0)
                     + (LW+1)'(gain);
         assign toppled_lv[r][c] = sum[LW] ? sgs_pkg::LEVEL_MAX : sum[LW-1:0];
      end
   end

   always_comb begin
      level_in = level_ff;
      if (dp_cmd.add_grain) begin
         if (level_ff[CENTER_ROW][CENTER_COL] != sgs_pkg::LEVEL_MAX) begin
            level_in[CENTER_ROW][CENTER_COL] = level_ff[CENTER_ROW][CENTER_COL] + 8'd1;
         end
      end else if (dp_cmd.topple) begin
         level_in = toppled_lv;
      end
   end

   // Count the latched topple flags one cell per cycle.
   assign scan_last = (scan_col_ff == CW'(GRID_WIDTH - 1))
                   && (scan_row_ff == RW'(GRID_HEIGHT - 1));

   always_comb begin
      flag_in     = flag_ff;
      scan_col_in = scan_col_ff;
      scan_row_in = scan_row_ff;
      count_in    = count_ff;
      if (dp_cmd.topple) begin
         flag_in     = hot;
         scan_col_in = '0;
         scan_row_in = '0;
         count_in    = '0;
      end else if (dp_cmd.scan_step) begin
         if (flag_ff[scan_row_ff][scan_col_ff] && count_ff != sgs_pkg::COUNT_MAX) begin
            count_in = count_ff + 8'd1;
         end
         if (scan_col_ff == CW'(GRID_WIDTH - 1)) begin
            scan_col_in = '0;
            scan_row_in = scan_row_ff + 1'b1;
         end else begin
            scan_col_in = scan_col_ff + 1'b1;
         end
      end
   end

   // Read path: coordinates latched at transfer, level fetched in the FETCH state from them.
   assign rd_inside = (rd_col_ff < XW'(GRID_WIDTH)) && (rd_row_ff < XW'(GRID_HEIGHT));

   always_comb begin
      rd_col_in   = rd_col_ff;
      rd_row_in   = rd_row_ff;
      rd_level_in = rd_level_ff;
      if (dp_cmd.capture) begin
         rd_col_in = XW'(req_payload.col);
         rd_row_in = XW'(req_payload.row);
      end
      if (dp_cmd.fetch) begin
         rd_level_in = rd_inside ? level_ff[rd_row_ff[RW-1:0]][rd_col_ff[CW-1:0]] : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (dp_cmd.load_tick) begin
         rsp_valid_in          = 1'b1;
         rsp_in.pixel_color    = '0;
         rsp_in.cell_level     = '0;
         rsp_in.toppled_count  = count_ff;
      end else if (dp_cmd.load_read) begin
         rsp_valid_in          = 1'b1;
         rsp_in.pixel_color    = sgs_pkg::color_of(rd_level_ff, colors);
         rsp_in.cell_level     = rd_level_ff;
         rsp_in.toppled_count  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < GRID_HEIGHT; r++) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
               level_ff[r][c] <= '0;
            end
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff     <= flag_in;
      scan_col_ff <= scan_col_in;
      scan_row_ff <= scan_row_in;
      count_ff    <= count_in;
      rd_col_ff   <= rd_col_in;
      rd_row_ff   <= rd_row_in;
      rd_level_ff <= rd_level_in;
      rsp_ff      <= rsp_in;
   end

   assign dp_status.scan_last = scan_last;
   assign dp_status.rsp_hold  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload         = rsp_ff;

endmodule

FILE: hw/rtl/sandpile_grid_step_core.sv
// Top level: abelian sandpile grid with colour registers on an APB-style port.
// Tick: grain, topple pass, then the toppled-cell count scans one cell per cycle.
// Read: cell fetch, then colour lookup into the output register.
// One item at a time; the next transfer is taken once the result is in the output register.
// Synchronous active-high reset clears the whole grid and the colour registers.
`timescale 1ns / 1ps
module sandpile_grid_step_core #(
   parameter int GRID_WIDTH  = sgs_pkg::GRID_WIDTH_DEFAULT,
   parameter int GRID_HEIGHT = sgs_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sgs_pkg::req_payload_type            req_payload,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sgs_pkg::rsp_payload_type            rsp_payload,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sgs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [sgs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [sgs_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);

   sgs_pkg::color_set_type colors_ff, colors_in;
   sgs_pkg::dp_cmd_type    dp_cmd;
   sgs_pkg::dp_status_type dp_status;

   logic       csr_write;
   logic [1:0] csr_index;

   // Register file: write on the access phase, index from the word address.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      colors_in = colors_ff;
      if (csr_write) begin
         unique case (csr_index)
            sgs_pkg::REG_LEVEL1_COLOR:   colors_in.level1   = pwdata[sgs_pkg::COLOR_WIDTH-1:0];
            sgs_pkg::REG_LEVEL2_COLOR:   colors_in.level2   = pwdata[sgs_pkg::COLOR_WIDTH-1:0];
            sgs_pkg::REG_LEVEL3_COLOR:   colors_in.level3   = pwdata[sgs_pkg::COLOR_WIDTH-1:0];
            sgs_pkg::REG_OVERFLOW_COLOR: colors_in.overflow = pwdata[sgs_pkg::COLOR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         sgs_pkg::REG_LEVEL1_COLOR:   prdata = 32'(colors_ff.level1);
         sgs_pkg::REG_LEVEL2_COLOR:   prdata = 32'(colors_ff.level2);
         sgs_pkg::REG_LEVEL3_COLOR:   prdata = 32'(colors_ff.level3);
         sgs_pkg::REG_OVERFLOW_COLOR: prdata = 32'(colors_ff.overflow);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colors_ff <= '0;
      end else begin
         colors_ff <= colors_in;
      end
   end

   // Controller sequences each transfer; datapath owns grid and result register.
   sgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   sgs_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .req_payload (req_payload),
      .colors      (colors_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
